// ===== hw/rtl/mrba_pkg.sv =====
`default_nettype none
package mrba_pkg;

  typedef enum logic [0:0] {
    CMD_CLEAR = 1'b0,
    CMD_PLACE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BIN_WIDTH  = 2'd0,
    REG_BIN_HEIGHT = 2'd1,
    REG_PADDING    = 2'd2,
    REG_EXTRUDE    = 2'd3
  } reg_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic        cmd;
    logic [15:0] region_width;
    logic [15:0] region_height;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] place_x;
    logic [15:0] place_y;
  } out_item_t;

  // Coordinates carry one extra bit so right and bottom edges never wrap.
  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] w;
    logic [16:0] h;
  } box_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_FIT_RD,
    S_FIT,
    S_SPLIT_RD,
    S_SPLIT,
    S_PRUNE_RD_I,
    S_PRUNE_RD_K,
    S_PRUNE_CMP,
    S_PRUNE_NEXT,
    S_COPY_RD,
    S_COPY_WR,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;       // latch item and compute sizes
    logic do_clear;    // install bin rectangle
    logic fit_rd;      // read free[i]
    logic fit_eval;    // score free[i]
    logic split_rd;    // read free[i] for split
    logic split_step;  // emit next piece of free[i]
    logic prune_rd_i;
    logic prune_rd_k;
    logic prune_cmp;
    logic prune_next;  // close out entry i
    logic copy_rd;
    logic copy_wr;
    logic finish;      // issued with the result load
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_place;
    logic fit_last;     // i is the last free entry (or none)
    logic split_piece_done; // all pieces of free[i] emitted
    logic split_last;
    logic split_ovf;
    logic prune_k_last;
    logic prune_covered;
    logic prune_i_last;
    logic kept_ovf;
    logic copy_last;
    logic found;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/maxrects_bssf_rect_allocator_top.sv =====
`default_nettype none
// Rectangle allocator for one bin (maximal free rectangles, best short side
// fit). A clear installs the bin rectangle; a place scores the free list,
// splits the free rectangles into scratch, prunes the scratch pieces pairwise
// and copies the survivors back to the free list. The prune loop through the
// single scratch read port sets the rate. One transaction is handled at a
// time; the result sits in an output register until taken.
module maxrects_bssf_rect_allocator_top #(
  parameter int unsigned MaxFree  = 32,
  parameter int unsigned MaxSplit = 128
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  mrba_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output mrba_pkg::out_item_t         out_data_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire  [mrba_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [mrba_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [15:0] bin_w_q, bin_h_q;
  logic [7:0]  pad_q, ext_q;
  mrba_pkg::ctl_t ctl;
  mrba_pkg::sts_t sts;
  mrba_pkg::out_item_t res;
  logic res_load;
  mrba_pkg::in_item_t item_q;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_w_q <= 16'd1024;
      bin_h_q <= 16'd1024;
      pad_q   <= '0;
      ext_q   <= '0;
    end else if (cfg_valid_i) begin
      case (mrba_pkg::reg_e'(cfg_index_i))
        mrba_pkg::REG_BIN_WIDTH:  bin_w_q <= cfg_data_i;
        mrba_pkg::REG_BIN_HEIGHT: bin_h_q <= cfg_data_i;
        mrba_pkg::REG_PADDING:    pad_q   <= cfg_data_i[7:0];
        mrba_pkg::REG_EXTRUDE:    ext_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign item_q = in_data_i;

  mrba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .res_load_o (res_load),
    .res_free_i (!out_valid_o || out_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mrba_dp #(
    .MaxFree  (MaxFree),
    .MaxSplit (MaxSplit)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_q),
    .bin_w_i   (bin_w_q),
    .bin_h_i   (bin_h_q),
    .padding_i (pad_q),
    .extrude_i (ext_q),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .res_o     (res)
  );

  // Hold the result until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_o <= res;
    end
  end

`ifndef SYNTHESIS
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status != 2'd3))
    else $error("status code out of range");
  a_no_pos_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != mrba_pkg::ST_OK) |->
      (out_data_o.place_x == '0 && out_data_o.place_y == '0))
    else $error("position reported on failure");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/mrba_ctrl.sv =====
`default_nettype none
module mrba_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            res_load_o,
  input  wire             res_free_i,
  input  mrba_pkg::sts_t  sts_i,
  output mrba_pkg::ctl_t  ctl_o
);

  mrba_pkg::state_e state_q, state_d;

  // Hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence the scan, split, prune and copy phases.
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    res_load_o = 1'b0;
    case (state_q)
      mrba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.start = 1'b1;
          state_d = mrba_pkg::S_CLEAR;
        end
      end
      mrba_pkg::S_CLEAR: begin
        if (!sts_i.is_place) begin
          ctl_o.do_clear = 1'b1;
          state_d = mrba_pkg::S_DONE;
        end else begin
          ctl_o.fit_rd = 1'b1;
          state_d = mrba_pkg::S_FIT_RD;
        end
      end
      mrba_pkg::S_FIT_RD: begin
        state_d = mrba_pkg::S_FIT;
      end
      mrba_pkg::S_FIT: begin
        ctl_o.fit_eval = 1'b1;
        if (sts_i.fit_last) begin
          state_d = mrba_pkg::S_SPLIT_RD;
        end else begin
          ctl_o.fit_rd = 1'b1;
          state_d = mrba_pkg::S_FIT_RD;
        end
      end
      mrba_pkg::S_SPLIT_RD: begin
        if (!sts_i.found) begin
          state_d = mrba_pkg::S_DONE;
        end else begin
          ctl_o.split_rd = 1'b1;
          state_d = mrba_pkg::S_SPLIT;
        end
      end
      mrba_pkg::S_SPLIT: begin
        ctl_o.split_step = 1'b1;
        if (sts_i.split_ovf) begin
          state_d = mrba_pkg::S_DONE;
        end else if (sts_i.split_piece_done) begin
          if (sts_i.split_last) begin
            state_d = mrba_pkg::S_PRUNE_RD_I;
          end else begin
            state_d = mrba_pkg::S_SPLIT_RD;
          end
        end
      end
      mrba_pkg::S_PRUNE_RD_I: begin
        ctl_o.prune_rd_i = 1'b1;
        state_d = mrba_pkg::S_PRUNE_RD_K;
      end
      mrba_pkg::S_PRUNE_RD_K: begin
        ctl_o.prune_rd_k = 1'b1;
        state_d = mrba_pkg::S_PRUNE_CMP;
      end
      mrba_pkg::S_PRUNE_CMP: begin
        ctl_o.prune_cmp = 1'b1;
        if (sts_i.prune_covered || sts_i.prune_k_last) begin
          state_d = mrba_pkg::S_PRUNE_NEXT;
        end else begin
          ctl_o.prune_rd_k = 1'b1;
          state_d = mrba_pkg::S_PRUNE_CMP;
        end
      end
      mrba_pkg::S_PRUNE_NEXT: begin
        ctl_o.prune_next = 1'b1;
        if (sts_i.prune_i_last) begin
          state_d = mrba_pkg::S_COPY_RD;
        end else begin
          state_d = mrba_pkg::S_PRUNE_RD_I;
        end
      end
      mrba_pkg::S_COPY_RD: begin
        if (sts_i.kept_ovf) begin
          state_d = mrba_pkg::S_DONE;
        end else begin
          ctl_o.copy_rd = 1'b1;
          state_d = mrba_pkg::S_COPY_WR;
        end
      end
      mrba_pkg::S_COPY_WR: begin
        ctl_o.copy_wr = 1'b1;
        if (sts_i.copy_last) begin
          state_d = mrba_pkg::S_DONE;
        end else begin
          state_d = mrba_pkg::S_COPY_RD;
        end
      end
      mrba_pkg::S_DONE: begin
        if (res_free_i) begin
          ctl_o.finish = 1'b1;
          res_load_o = 1'b1;
          state_d = mrba_pkg::S_IDLE;
        end
      end
      default: state_d = mrba_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mrba_dp.sv =====
`default_nettype none
module mrba_dp #(
  parameter int unsigned MaxFree  = 32,
  parameter int unsigned MaxSplit = 128
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  mrba_pkg::in_item_t   item_i,
  input  wire  [15:0]          bin_w_i,
  input  wire  [15:0]          bin_h_i,
  input  wire  [7:0]           padding_i,
  input  wire  [7:0]           extrude_i,
  input  mrba_pkg::ctl_t       ctl_i,
  output mrba_pkg::sts_t       sts_o,
  output mrba_pkg::out_item_t  res_o
);

  localparam int unsigned FA = (MaxFree > 1) ? $clog2(MaxFree) : 1;
  localparam int unsigned FC = $clog2(MaxFree + 1);
  localparam int unsigned SA = $clog2(MaxSplit);
  localparam int unsigned SC = $clog2(MaxSplit + 1);
  localparam int unsigned KC = $clog2(MaxSplit + 1);

  // Free list, scratch list and per-piece keep flag memories.
  mrba_pkg::box_t free_mem [MaxFree];
  mrba_pkg::box_t split_mem [MaxSplit];
  logic           kept_mem [MaxSplit];

  logic [FC-1:0] free_cnt_q;
  logic          is_place_q;
  logic [17:0]   across_q, down_q;
  logic [FC-1:0] fi_q;          // free index for scan and split
  logic [SC-1:0] scnt_q;        // split count
  logic [SC-1:0] pi_q;          // prune index i
  logic [SC-1:0] pk_q;          // prune index k
  logic [KC-1:0] kept_cnt_q;
  logic [FC-1:0] wr_q;          // copy write index
  logic [SC-1:0] cr_q;          // copy read index
  logic          found_q;
  logic [17:0]   best_s_q;
  logic [16:0]   best_x_q, best_y_q;
  logic          ovf_q;
  logic          covered_q;
  logic [1:0]    piece_q;
  mrba_pkg::box_t fr_q, si_q, sk_q;
  logic          kept_rd_q;

  logic [9:0]    border;
  logic [17:0]   fit_s, dw, dh;
  logic          fits;
  logic [17:0]   cr, cb, ur, ub;
  logic          disj, push_v, last_piece, ovf_next;
  mrba_pkg::box_t piece;
  logic [FA-1:0] frd_addr;
  logic [SA-1:0] srd_addr;
  logic [SC-1:0] kk;
  logic          cover_hit, keep_i, kept_ovf, copy_last;
  logic [16:0]   rx, ry;

  // Latch the item and the bordered size.
  assign border = {1'b0, extrude_i, 1'b0} + {2'b00, padding_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= '0;
      is_place_q <= 1'b0;
      fi_q       <= '0;
      scnt_q     <= '0;
      pi_q       <= '0;
      pk_q       <= '0;
      kept_cnt_q <= '0;
      wr_q       <= '0;
      cr_q       <= '0;
      found_q    <= 1'b0;
      ovf_q      <= 1'b0;
      covered_q  <= 1'b0;
      piece_q    <= '0;
    end else begin
      if (ctl_i.start) begin
        is_place_q <= item_i.cmd;
        fi_q       <= '0;
        scnt_q     <= '0;
        pi_q       <= '0;
        kept_cnt_q <= '0;
        wr_q       <= '0;
        cr_q       <= '0;
        found_q    <= 1'b0;
        ovf_q      <= 1'b0;
        piece_q    <= '0;
      end
      if (ctl_i.do_clear) begin
        free_cnt_q <= FC'(1);
      end
      // Advance the scan; rewind it for the split pass after the last entry.
      if (ctl_i.fit_rd) begin
        fi_q <= fi_q + FC'(1);
      end else if (ctl_i.fit_eval && (fi_q >= free_cnt_q)) begin
        fi_q <= '0;
      end
      if (ctl_i.fit_eval && fits && (!found_q || fit_s < best_s_q)) begin
        found_q <= 1'b1;
      end
      if (ctl_i.split_step) begin
        if (push_v && scnt_q == SC'(MaxSplit)) begin
          ovf_q <= 1'b1;
        end else if (push_v) begin
          scnt_q <= scnt_q + SC'(1);
        end
        if (last_piece) begin
          piece_q <= '0;
          fi_q    <= fi_q + FC'(1);
        end else begin
          piece_q <= piece_q + 2'd1;
        end
      end
      if (ctl_i.prune_rd_i) begin
        pk_q      <= '0;
        covered_q <= 1'b0;
      end
      if (ctl_i.prune_rd_k) begin
        pk_q <= pk_q + SC'(1);
      end
      if (ctl_i.prune_cmp && cover_hit) begin
        covered_q <= 1'b1;
      end
      if (ctl_i.prune_next) begin
        if (keep_i) begin
          kept_cnt_q <= kept_cnt_q + KC'(1);
        end
        pi_q <= pi_q + SC'(1);
      end
      // Walk the scratch list, writing back only kept pieces.
      if (ctl_i.copy_wr) begin
        if (kept_rd_q) begin
          wr_q <= wr_q + FC'(1);
        end
        cr_q <= cr_q + SC'(1);
        if (copy_last) begin
          free_cnt_q <= FC'(kept_cnt_q);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      across_q <= {2'b00, item_i.region_width} + {8'd0, border};
      down_q   <= {2'b00, item_i.region_height} + {8'd0, border};
      best_s_q <= '0;
    end
    if (ctl_i.fit_eval && fits && (!found_q || fit_s < best_s_q)) begin
      best_s_q <= fit_s;
      best_x_q <= fr_q.x;
      best_y_q <= fr_q.y;
    end
  end

  // Free list memory: one write and one registered read port.
  always_comb begin
    frd_addr = fi_q[FA-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.do_clear) begin
      free_mem[0] <= '{x: 17'd0, y: 17'd0, w: {1'b0, bin_w_i}, h: {1'b0, bin_h_i}};
    end else if (ctl_i.copy_wr && kept_rd_q) begin
      free_mem[wr_q[FA-1:0]] <= sk_q;
    end
    if (ctl_i.fit_rd || ctl_i.split_rd) begin
      fr_q <= free_mem[frd_addr];
    end
  end

  // Score of the candidate.
  always_comb begin
    dw = {1'b0, fr_q.w} - across_q;
    dh = {1'b0, fr_q.h} - down_q;
    fits = ({1'b0, fr_q.w} >= across_q) && ({1'b0, fr_q.h} >= down_q)
           && (fi_q <= free_cnt_q);
    fit_s = (dw < dh) ? dw : dh;
    if (!fits) fit_s = '1;
  end

  // Split pieces of the current free rectangle against the used box.
  always_comb begin
    cr   = {1'b0, fr_q.x} + {1'b0, fr_q.w};
    cb   = {1'b0, fr_q.y} + {1'b0, fr_q.h};
    ur   = {1'b0, best_x_q} + across_q;
    ub   = {1'b0, best_y_q} + down_q;
    disj = ({1'b0, best_x_q} >= cr) || (ur <= {1'b0, fr_q.x}) ||
           ({1'b0, best_y_q} >= cb) || (ub <= {1'b0, fr_q.y});
    piece = fr_q;
    push_v = 1'b0;
    last_piece = (piece_q == 2'd3) || disj;
    if (disj) begin
      push_v = 1'b1;
    end else begin
      case (piece_q)
        2'd0: begin
          push_v = best_x_q > fr_q.x;
          piece.w = best_x_q - fr_q.x;
        end
        2'd1: begin
          push_v = ur < cr;
          piece.x = ur[16:0];
          piece.w = 17'(cr - ur);
        end
        2'd2: begin
          push_v = best_y_q > fr_q.y;
          piece.h = best_y_q - fr_q.y;
        end
        default: begin
          push_v = ub < cb;
          piece.y = ub[16:0];
          piece.h = 17'(cb - ub);
        end
      endcase
    end
    ovf_next = push_v && (scnt_q == SC'(MaxSplit));
  end

  // Scratch memory: write pieces, read i, k or the copy entry.
  always_comb begin
    srd_addr = ctl_i.prune_rd_i ? pi_q[SA-1:0] :
               ctl_i.copy_rd ? cr_q[SA-1:0] : pk_q[SA-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.split_step && push_v && !ovf_next) begin
      split_mem[scnt_q[SA-1:0]] <= piece;
    end
    if (ctl_i.prune_rd_i) begin
      si_q <= split_mem[srd_addr];
    end else if (ctl_i.prune_rd_k || ctl_i.copy_rd) begin
      sk_q <= split_mem[srd_addr];
    end
  end

  // Keep flags: written as each piece closes out, read back during the copy.
  always_ff @(posedge clk_i) begin
    if (ctl_i.prune_next) begin
      kept_mem[pi_q[SA-1:0]] <= keep_i;
    end
    if (ctl_i.copy_rd) begin
      kept_rd_q <= kept_mem[cr_q[SA-1:0]];
    end
  end

  // Containment tests between scratch entries i and k.
  function automatic logic inside_f(mrba_pkg::box_t o, mrba_pkg::box_t n);
    logic [17:0] orr, obb, nrr, nbb;
    orr = {1'b0, o.x} + {1'b0, o.w};
    obb = {1'b0, o.y} + {1'b0, o.h};
    nrr = {1'b0, n.x} + {1'b0, n.w};
    nbb = {1'b0, n.y} + {1'b0, n.h};
    return (n.x >= o.x) && (n.y >= o.y) && (nrr <= orr) && (nbb <= obb);
  endfunction

  assign kk = pk_q - SC'(1);
  always_comb begin
    cover_hit = (kk != pi_q) && inside_f(sk_q, si_q) &&
                (!inside_f(si_q, sk_q) || (kk < pi_q));
  end
  assign keep_i   = !covered_q && (pi_q < scnt_q);
  assign kept_ovf = kept_cnt_q > KC'(MaxFree);

  // Done once the last kept piece is written, or at once when none is kept.
  assign copy_last = (kept_cnt_q == '0) ||
                     (kept_rd_q && ((KC'(wr_q) + KC'(1)) == kept_cnt_q));

  // Status to controller.
  always_comb begin
    sts_o = '0;
    sts_o.is_place         = is_place_q;
    sts_o.fit_last         = fi_q >= free_cnt_q;
    sts_o.split_piece_done = last_piece;
    sts_o.split_last       = (fi_q + FC'(1)) >= free_cnt_q;
    sts_o.split_ovf        = ovf_next;
    sts_o.prune_k_last     = pk_q >= scnt_q;
    sts_o.prune_covered    = cover_hit;
    sts_o.prune_i_last     = (pi_q + SC'(1)) >= scnt_q;
    sts_o.kept_ovf         = kept_ovf;
    sts_o.copy_last        = copy_last;
    sts_o.found            = found_q;
  end

  // Result.
  assign rx = best_x_q + {9'd0, extrude_i};
  assign ry = best_y_q + {9'd0, extrude_i};
  always_comb begin
    res_o = '0;
    if (is_place_q) begin
      if (!found_q) begin
        res_o.status = mrba_pkg::ST_NO_FIT;
      end else if (ovf_q || kept_ovf) begin
        res_o.status = mrba_pkg::ST_OVERFLOW;
      end else begin
        res_o.place_x = rx[15:0];
        res_o.place_y = ry[15:0];
      end
    end
  end

endmodule
`default_nettype wire
